@@ rtl/core/lrff_pkg.sv @@
package lrff_pkg;

  localparam int MAX_SAMPLES_DEF = 1024;

  localparam int COUNT_W = 16;
  localparam int Z_W     = 31;
  localparam int RES_Z_W = 32;
  localparam int SPAN_W  = 10;
  localparam int DIST_W  = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 136;

  typedef logic signed [Z_W-1:0]     z_t;
  typedef logic signed [RES_Z_W-1:0] res_z_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_TOP    = 2'd1,
    ST_NO_BOTTOM = 2'd2,
    ST_MISMATCH  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNT_THRESHOLD = 3'd0,
    CFG_MIN_RUN_SPAN    = 3'd1,
    CFG_LOCK_MODEL      = 3'd2,
    CFG_LAYER_STEP      = 3'd3,
    CFG_BASE_THICKNESS  = 3'd4,
    CFG_THICK_TOL       = 3'd5
  } cfg_idx_t;

endpackage

@@ rtl/core/layer_run_focus_finder_unit.sv @@
// Throughput: one sample per cycle while s_tready is high (back-pressure can stall it);
// samples that are not last produce no result beat. Per-sample run tracking is one
// compare/update step on the sweep registers; the result then passes stage a (sweep snapshot),
// stage b (inner Zs), stage c (outer Zs, thickness difference) and the output register.
// Reset (rst, synchronous) clears the sweep state, the config registers and all valid flags.
// A last sample returns the sweep state to its reset values in the same cycle.
module layer_run_focus_finder_unit
  import lrff_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] cluster_count, [46:16] sample_z, pad
  input  logic                   s_tlast,   // last_sample
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [1:0] status, [33:2] top_inner_z,
                                            // [65:34] bottom_inner_z, [97:66] top_outer_z,
                                            // [129:98] bottom_outer_z, pad
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W   = $clog2(MAX_SAMPLES + 1);
  localparam int START_W = $clog2(MAX_SAMPLES);
  localparam int SPC_W   = (IDX_W > SPAN_W) ? IDX_W : SPAN_W;
  localparam int DIFF_W  = RES_Z_W + 2;

  // config registers
  logic [COUNT_W-1:0] count_threshold;
  logic [SPAN_W-1:0]  min_run_span;
  logic               lock_model;
  logic [DIST_W-1:0]  layer_step;
  logic [DIST_W-1:0]  base_thickness;
  logic [DIST_W-1:0]  thickness_tolerance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_threshold     <= '0;
      min_run_span        <= '0;
      lock_model          <= 1'b0;
      layer_step          <= '0;
      base_thickness      <= '0;
      thickness_tolerance <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COUNT_THRESHOLD: count_threshold     <= cfg_data[COUNT_W-1:0];
        CFG_MIN_RUN_SPAN:    min_run_span        <= cfg_data[SPAN_W-1:0];
        CFG_LOCK_MODEL:      lock_model          <= cfg_data[0];
        CFG_LAYER_STEP:      layer_step          <= cfg_data[DIST_W-1:0];
        CFG_BASE_THICKNESS:  base_thickness      <= cfg_data[DIST_W-1:0];
        CFG_THICK_TOL:       thickness_tolerance <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [COUNT_W-1:0] in_count;
  z_t                 in_z;
  assign in_count = s_tdata[COUNT_W-1:0];
  assign in_z     = z_t'(s_tdata[COUNT_W+Z_W-1:COUNT_W]);

  // pipeline handshake
  logic a_valid, b_valid, c_valid;
  logic out_free, c_free, b_free, a_free, accept;

  assign out_free = !m_tvalid || m_tready;
  assign c_free   = !c_valid || out_free;
  assign b_free   = !b_valid || c_free;
  assign a_free   = !a_valid || b_free;
  assign s_tready = a_free;
  assign accept   = s_tvalid && s_tready;

  // sweep state
  logic [IDX_W-1:0]   sample_index;
  logic               in_run;
  logic [1:0]         runs_found;
  logic [START_W-1:0] run_start_index;
  z_t                 run_start_z;
  z_t                 previous_z;
  z_t                 run_edge_z [4];

  logic             active, below, close_run, open_run, record;
  logic [IDX_W-1:0] span;
  logic [1:0]       runs_next;
  z_t               edge_next [4];

  always_comb begin
    active    = (runs_found < 2'd2) && (sample_index < IDX_W'(MAX_SAMPLES));
    below     = in_count < count_threshold;
    span      = sample_index - IDX_W'(1) - IDX_W'(run_start_index);
    close_run = active && in_run && below;
    open_run  = active && !in_run && !below;
    record    = close_run && (SPC_W'(span) >= SPC_W'(min_run_span));
    runs_next = runs_found + {1'b0, record};
    for (int i = 0; i < 4; i++) begin
      edge_next[i] = run_edge_z[i];
    end
    // only zero or one run is on record while the sweep is active
    if (record) begin
      if (runs_found[0]) begin
        edge_next[2] = run_start_z;
        edge_next[3] = previous_z;
      end else begin
        edge_next[0] = run_start_z;
        edge_next[1] = previous_z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index    <= '0;
      in_run          <= 1'b0;
      runs_found      <= '0;
      run_start_index <= '0;
      run_start_z     <= '0;
      previous_z      <= '0;
      for (int i = 0; i < 4; i++) begin
        run_edge_z[i] <= '0;
      end
    end else if (accept) begin
      if (s_tlast) begin
        sample_index    <= '0;
        in_run          <= 1'b0;
        runs_found      <= '0;
        run_start_index <= '0;
        run_start_z     <= '0;
        previous_z      <= '0;
        for (int i = 0; i < 4; i++) begin
          run_edge_z[i] <= '0;
        end
      end else if (active) begin
        sample_index <= sample_index + IDX_W'(1);
        previous_z   <= in_z;
        runs_found   <= runs_next;
        for (int i = 0; i < 4; i++) begin
          run_edge_z[i] <= edge_next[i];
        end
        if (close_run) begin
          in_run <= 1'b0;
        end else if (open_run) begin
          in_run          <= 1'b1;
          run_start_index <= sample_index[START_W-1:0];
          run_start_z     <= in_z;
        end
      end
    end
  end

  // stage a: sweep snapshot on a last sample
  logic [1:0] a_runs;
  z_t         a_edge [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= accept && s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      a_runs <= active ? runs_next : runs_found;
      for (int i = 0; i < 4; i++) begin
        a_edge[i] <= active ? edge_next[i] : run_edge_z[i];
      end
    end
  end

  // stage b: inner Zs
  logic signed [RES_Z_W:0] top_sum, bot_sum;
  res_z_t                  top_inner, bot_inner;
  logic                    b_two;
  status_t                 b_status;
  res_z_t                  b_ti, b_bi;

  always_comb begin
    top_sum = {{2{a_edge[1][Z_W-1]}}, a_edge[1]} + {{2{a_edge[0][Z_W-1]}}, a_edge[0]}
            - $signed({{(RES_Z_W+1-DIST_W){1'b0}}, layer_step});
    bot_sum = {{2{a_edge[3][Z_W-1]}}, a_edge[3]} + {{2{a_edge[2][Z_W-1]}}, a_edge[2]}
            + $signed({{(RES_Z_W+1-DIST_W){1'b0}}, layer_step});
    if (lock_model) begin
      // floor halving: drop the low bit of the two's complement sum
      top_inner = top_sum[RES_Z_W:1];
      bot_inner = bot_sum[RES_Z_W:1];
    end else begin
      top_inner = {a_edge[1][Z_W-1], a_edge[1]};
      bot_inner = {a_edge[2][Z_W-1], a_edge[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free && a_valid) begin
      b_two <= a_runs[1];
      case (a_runs)
        2'd0:    b_status <= ST_NO_TOP;
        2'd1:    b_status <= ST_NO_BOTTOM;
        default: b_status <= ST_OK;
      endcase
      b_ti <= a_runs[1] ? top_inner : '0;
      b_bi <= a_runs[1] ? bot_inner : '0;
    end
  end

  // stage c: outer Zs and thickness difference
  logic                     c_two;
  status_t                  c_status;
  res_z_t                   c_ti, c_bi, c_to, c_bo;
  logic signed [DIFF_W-1:0] c_diff;
  logic signed [DIFF_W-1:0] step_ext;

  assign step_ext = $signed({{(DIFF_W-DIST_W){1'b0}}, layer_step});

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_free) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_free && b_valid) begin
      c_two    <= b_two;
      c_status <= b_status;
      c_ti     <= b_ti;
      c_bi     <= b_bi;
      c_to     <= b_two ? res_z_t'(b_ti + res_z_t'(step_ext)) : '0;
      c_bo     <= b_two ? res_z_t'(b_bi - res_z_t'(step_ext)) : '0;
      c_diff   <= {{2{b_ti[RES_Z_W-1]}}, b_ti} - {{2{b_bi[RES_Z_W-1]}}, b_bi}
                - $signed({{(DIFF_W-DIST_W){1'b0}}, base_thickness});
    end
  end

  // output register
  logic signed [DIFF_W-1:0] tol_ext;
  logic                     in_tol;
  status_t                  out_status;
  res_z_t                   out_ti, out_bi, out_to, out_bo;

  assign tol_ext = $signed({{(DIFF_W-DIST_W){1'b0}}, thickness_tolerance});
  assign in_tol  = (c_diff <= tol_ext) && (c_diff >= -tol_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && c_valid) begin
      out_status <= c_two ? (in_tol ? ST_OK : ST_MISMATCH) : c_status;
      out_ti     <= c_ti;
      out_bi     <= c_bi;
      out_to     <= c_to;
      out_bo     <= c_bo;
    end
  end

  assign m_tdata = {6'b0, out_bo, out_to, out_bi, out_ti, out_status};

  // checks
  a_runs_bound: assert property (@(posedge clk) disable iff (rst)
    runs_found <= 2'd2)
    else $error("more than two runs on record");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    sample_index <= IDX_W'(MAX_SAMPLES))
    else $error("sample index past sweep limit");

  a_run_order: assert property (@(posedge clk) disable iff (rst)
    in_run |-> (IDX_W'(run_start_index) < sample_index))
    else $error("open run starts at or after current sample");

  a_sweep_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (sample_index == '0 && runs_found == 2'd0 && !in_run && a_valid))
    else $error("last sample did not close the sweep");

endmodule
